// ===== rtl/core/tree_diameter_double_sweep_defines.svh =====
// Assertion helpers for the tree diameter block.
`ifndef TREE_DIAMETER_DOUBLE_SWEEP_DEFINES_SVH
`define TREE_DIAMETER_DOUBLE_SWEEP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TDDS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDDS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tdds_pkg.sv =====
// ----------------------------------------------------------------------------
// tdds_pkg
// Shared constants, controller states and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tdds_pkg;

  localparam int VERT_W           = 6;
  localparam int COST_PORT_W      = 32;
  localparam int DIAM_W           = 38;
  localparam int CFG_W            = 7;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COST_BITS_DEF    = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LA_RD,
    ST_LA_WR,
    ST_LB_RD,
    ST_LB_WR,
    ST_SW_INIT,
    ST_SW_HEAD,
    ST_SW_EDGE,
    ST_SW_VISIT,
    ST_SW_POP,
    ST_EMIT,
    ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic capture;    // latch edge fields
    logic app_rd;     // append: write new entry, read owner tail
    logic app_wr;     // append: link entry, update list ends
    logic app_sel;    // 0: from->to, 1: to->from
    logic second;     // second sweep (records parents)
    logic sw_init;
    logic head_take;
    logic edge_rd;
    logic visit;
    logic pop_rd;
    logic pop_take;
    logic emit_init;
    logic emit;
    logic emit_rd;
    logic emit_take;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic op_compute;
    logic load_ok;
    logic cursor_null;
    logic stack_empty;
    logic push;
    logic path_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/tdds_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdds_ctrl
// Sequencer for edge loads, the two depth-first sweeps and path emission.
// ----------------------------------------------------------------------------
module tdds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tdds_pkg::dp_stat_t stat,
  output tdds_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  tdds_pkg::state_t state, state_next;
  logic             pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdds_pkg::ST_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    case (state)
      tdds_pkg::ST_IDLE: begin
        if (start) begin
          if (stat.op_compute) begin
            state_next = tdds_pkg::ST_SW_INIT;
            pass_next  = 1'b0;
          end else if (stat.load_ok) begin
            state_next = tdds_pkg::ST_LA_RD;
          end
        end
      end
      tdds_pkg::ST_LA_RD:    state_next = tdds_pkg::ST_LA_WR;
      tdds_pkg::ST_LA_WR:    state_next = tdds_pkg::ST_LB_RD;
      tdds_pkg::ST_LB_RD:    state_next = tdds_pkg::ST_LB_WR;
      tdds_pkg::ST_LB_WR:    state_next = tdds_pkg::ST_IDLE;
      tdds_pkg::ST_SW_INIT:  state_next = tdds_pkg::ST_SW_HEAD;
      tdds_pkg::ST_SW_HEAD:  state_next = tdds_pkg::ST_SW_EDGE;
      tdds_pkg::ST_SW_EDGE: begin
        if (!stat.cursor_null) begin
          state_next = tdds_pkg::ST_SW_VISIT;
        end else if (!stat.stack_empty) begin
          state_next = tdds_pkg::ST_SW_POP;
        end else if (!pass) begin
          pass_next  = 1'b1;
          state_next = tdds_pkg::ST_SW_INIT;
        end else begin
          state_next = tdds_pkg::ST_EMIT;
        end
      end
      tdds_pkg::ST_SW_VISIT: begin
        state_next = stat.push ? tdds_pkg::ST_SW_HEAD : tdds_pkg::ST_SW_EDGE;
      end
      tdds_pkg::ST_SW_POP:   state_next = tdds_pkg::ST_SW_EDGE;
      tdds_pkg::ST_EMIT: begin
        state_next = stat.path_last ? tdds_pkg::ST_IDLE : tdds_pkg::ST_EMIT_WAIT;
      end
      tdds_pkg::ST_EMIT_WAIT: state_next = tdds_pkg::ST_EMIT;
      default:               state_next = tdds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.second = pass;
    busy       = (state != tdds_pkg::ST_IDLE);
    case (state)
      tdds_pkg::ST_IDLE:     cmd.capture = start;
      tdds_pkg::ST_LA_RD:    cmd.app_rd  = 1'b1;
      tdds_pkg::ST_LA_WR:    cmd.app_wr  = 1'b1;
      tdds_pkg::ST_LB_RD: begin
        cmd.app_rd  = 1'b1;
        cmd.app_sel = 1'b1;
      end
      tdds_pkg::ST_LB_WR: begin
        cmd.app_wr  = 1'b1;
        cmd.app_sel = 1'b1;
      end
      tdds_pkg::ST_SW_INIT:  cmd.sw_init   = 1'b1;
      tdds_pkg::ST_SW_HEAD:  cmd.head_take = 1'b1;
      tdds_pkg::ST_SW_EDGE: begin
        if (!stat.cursor_null) begin
          cmd.edge_rd = 1'b1;
        end else if (!stat.stack_empty) begin
          cmd.pop_rd = 1'b1;
        end else if (pass) begin
          cmd.emit_init = 1'b1;
        end
      end
      tdds_pkg::ST_SW_VISIT: cmd.visit    = 1'b1;
      tdds_pkg::ST_SW_POP:   cmd.pop_take = 1'b1;
      tdds_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.path_last) begin
          cmd.clear = 1'b1;
        end else begin
          cmd.emit_rd = 1'b1;
        end
      end
      tdds_pkg::ST_EMIT_WAIT: cmd.emit_take = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tdds_dp.sv =====
// ----------------------------------------------------------------------------
// tdds_dp
// Edge store, walk stack, parent table and sweep/path registers.
// ----------------------------------------------------------------------------
module tdds_dp #(
  parameter int MAX_VERTICES = tdds_pkg::MAX_VERTICES_DEF,
  parameter int COST_BITS    = tdds_pkg::COST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tdds_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            operation,
  input  logic [tdds_pkg::VERT_W-1:0]     edge_from,
  input  logic [tdds_pkg::VERT_W-1:0]     edge_to,
  input  logic [tdds_pkg::COST_PORT_W-1:0] edge_cost,
  input  tdds_pkg::dp_cmd_t               cmd,
  output tdds_pkg::dp_stat_t              stat,
  output logic [tdds_pkg::VERT_W-1:0]     path_vertex,
  output logic [tdds_pkg::VERT_W-1:0]     far_end,
  output logic [tdds_pkg::VERT_W-1:0]     near_end,
  output logic [tdds_pkg::DIAM_W-1:0]     diameter_length,
  output logic                            last_of_path
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int ES = 2 * (MAX_VERTICES - 1);
  localparam int EW = $clog2(ES + 1);
  localparam int AW = (ES > 1) ? $clog2(ES) : 1;
  localparam int CW = (COST_BITS < tdds_pkg::COST_PORT_W) ? COST_BITS : tdds_pkg::COST_PORT_W;
  localparam int DW = tdds_pkg::DIAM_W;
  localparam int NW = tdds_pkg::CFG_W;
  localparam int FW = VW + EW + DW;

  // configuration
  logic [NW-1:0] vertex_count, n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= NW'(1);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = NW'(1);
    end else if (vertex_count > NW'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  // captured edge
  logic [VW-1:0] in_from, in_to;
  logic [CW-1:0] in_cost;
  logic [EW-1:0] edge_count;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_from <= edge_from[VW-1:0];
      in_to   <= edge_to[VW-1:0];
      in_cost <= edge_cost[CW-1:0];
    end
  end

  assign stat.op_compute = operation;
  assign stat.load_ok = ({1'b0, edge_from} < NW'(MAX_VERTICES)) &&
                        ({1'b0, edge_to} < NW'(MAX_VERTICES)) &&
                        ((EW + 1)'(edge_count) + (EW + 1)'(2) <= (EW + 1)'(ES));

  logic [VW-1:0] owner, other;
  assign owner = cmd.app_sel ? in_to : in_from;
  assign other = cmd.app_sel ? in_from : in_to;

  // sweep registers
  logic [MAX_VERTICES-1:0] head_valid, seen;
  logic [VW-1:0]           top_vertex, best_vertex, near_v, far_v, path_r, start_v;
  logic [EW-1:0]           top_cursor;
  logic [DW-1:0]           top_dist, best_dist, diam;
  logic [VW-1:0]           sp_mem, k_cnt;

  // memory read data
  logic [EW-1:0] tail_q, head_q, next_q;
  logic          hv_q, tv_q;
  logic [VW-1:0] nb_q, parent_q;
  logic [CW-1:0] cost_q;
  logic [FW-1:0] stack_q;

  logic [DW-1:0] cand_dist;
  logic          push;

  assign start_v   = cmd.second ? best_vertex : '0;
  assign cand_dist = top_dist + DW'(cost_q);
  assign push      = (NW'(nb_q) < n_eff) && !seen[nb_q];

  // edge entry memories
  logic [VW-1:0] nb_mem   [ES];
  logic [CW-1:0] cost_mem [ES];
  logic [EW-1:0] next_mem [ES];

  always_ff @(posedge clk) begin
    if (cmd.app_rd) begin
      nb_mem[edge_count[AW-1:0]]   <= other;
      cost_mem[edge_count[AW-1:0]] <= in_cost;
    end
    if (cmd.edge_rd) begin
      nb_q   <= nb_mem[top_cursor[AW-1:0]];
      cost_q <= cost_mem[top_cursor[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_rd) begin
      next_mem[edge_count[AW-1:0]] <= EW'(ES);
    end else if (cmd.app_wr && tv_q) begin
      next_mem[tail_q[AW-1:0]] <= edge_count;
    end
    if (cmd.edge_rd) begin
      next_q <= next_mem[top_cursor[AW-1:0]];
    end
  end

  // list ends
  logic [EW-1:0] head_mem [MAX_VERTICES];
  logic [EW-1:0] tail_mem [MAX_VERTICES];
  logic [VW-1:0] head_addr;

  assign head_addr = cmd.sw_init ? start_v : nb_q;

  always_ff @(posedge clk) begin
    if (cmd.app_wr && !tv_q) begin
      head_mem[owner] <= edge_count;
    end
    if (cmd.sw_init || (cmd.visit && push)) begin
      head_q <= head_mem[head_addr];
      hv_q   <= head_valid[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app_wr) begin
      tail_mem[owner] <= edge_count;
    end
    if (cmd.app_rd) begin
      tail_q <= tail_mem[owner];
      tv_q   <= head_valid[owner];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      edge_count <= '0;
    end else if (cmd.clear) begin
      head_valid <= '0;
      edge_count <= '0;
    end else if (cmd.app_wr) begin
      head_valid[owner] <= 1'b1;
      edge_count        <= edge_count + EW'(1);
    end
  end

  // walk stack (frames below the top)
  logic [FW-1:0] stack_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (cmd.visit && push) begin
      stack_mem[sp_mem] <= {top_vertex, next_q, top_dist};
    end
    if (cmd.pop_rd) begin
      stack_q <= stack_mem[sp_mem - VW'(1)];
    end
  end

  // parent table
  logic [VW-1:0] parent_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (cmd.sw_init && cmd.second) begin
      parent_mem[start_v] <= start_v;
    end else if (cmd.visit && push && cmd.second) begin
      parent_mem[nb_q] <= top_vertex;
    end
    if (cmd.emit_rd) begin
      parent_q <= parent_mem[path_r];
    end
  end

  // sweep state
  always_ff @(posedge clk) begin
    if (rst) begin
      best_vertex <= '0;
      best_dist   <= '0;
    end else if (cmd.sw_init) begin
      best_vertex <= start_v;
      best_dist   <= '0;
    end else if (cmd.visit && push && (cand_dist > best_dist)) begin
      best_vertex <= nb_q;
      best_dist   <= cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_init) begin
      seen       <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << start_v;
      top_vertex <= start_v;
      top_dist   <= '0;
      sp_mem     <= '0;
      if (cmd.second) begin
        near_v <= best_vertex;
      end
    end else if (cmd.head_take) begin
      top_cursor <= hv_q ? head_q : EW'(ES);
    end else if (cmd.visit) begin
      top_cursor <= next_q;
      if (push) begin
        seen[nb_q] <= 1'b1;
        sp_mem     <= sp_mem + VW'(1);
        top_vertex <= nb_q;
        top_dist   <= cand_dist;
      end
    end else if (cmd.pop_rd) begin
      sp_mem <= sp_mem - VW'(1);
    end else if (cmd.pop_take) begin
      {top_vertex, top_cursor, top_dist} <= stack_q;
    end
  end

  // path emission
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      path_r <= best_vertex;
      far_v  <= best_vertex;
      diam   <= best_dist;
      k_cnt  <= '0;
    end else if (cmd.emit_rd) begin
      k_cnt <= k_cnt + VW'(1);
    end else if (cmd.emit_take) begin
      path_r <= parent_q;
    end
  end

  assign stat.cursor_null = (top_cursor == EW'(ES));
  assign stat.stack_empty = (sp_mem == '0);
  assign stat.push        = push;
  assign stat.path_last   = (path_r == near_v) || (k_cnt == VW'(MAX_VERTICES - 1));

  assign path_vertex     = tdds_pkg::VERT_W'(path_r);
  assign far_end         = tdds_pkg::VERT_W'(far_v);
  assign near_end        = tdds_pkg::VERT_W'(near_v);
  assign diameter_length = diam;
  assign last_of_path    = stat.path_last;

endmodule

// ===== rtl/core/tree_diameter_double_sweep.sv =====
// Edge load: the accepted transaction is followed by the append states LA_RD, LA_WR, LB_RD
//   and LB_WR with busy high; a rejected load leaves the block idle.
// Compute: two depth-first sweeps over the single-port edge store and walk stack, then
//   path emission with a parent table read per path vertex; busy drops the cycle after
//   the last result.
// Synchronous active-high reset: edge store empty, vertex_count = 1, idle; no stalls.
// ----------------------------------------------------------------------------
// tree_diameter_double_sweep
// Tree diameter by two depth-first sweeps; emits the diameter path vertex by vertex.
// ----------------------------------------------------------------------------
module tree_diameter_double_sweep #(
  parameter int MAX_VERTICES = tdds_pkg::MAX_VERTICES_DEF,
  parameter int COST_BITS    = tdds_pkg::COST_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: vertices in use
  input  logic                             cfg_we,
  input  logic [tdds_pkg::CFG_W-1:0]       cfg_data,
  // command transaction
  input  logic                             start,
  output logic                             busy,
  input  logic                             operation,
  input  logic [tdds_pkg::VERT_W-1:0]      edge_from,
  input  logic [tdds_pkg::VERT_W-1:0]      edge_to,
  input  logic [tdds_pkg::COST_PORT_W-1:0] edge_cost,
  // result transactions, one cycle each
  output logic                             result_valid,
  output logic [tdds_pkg::VERT_W-1:0]      path_vertex,
  output logic [tdds_pkg::VERT_W-1:0]      far_end,
  output logic [tdds_pkg::VERT_W-1:0]      near_end,
  output logic [tdds_pkg::DIAM_W-1:0]      diameter_length,
  output logic                             last_of_path
);

  tdds_pkg::dp_cmd_t  cmd;
  tdds_pkg::dp_stat_t stat;

  // Controller: accepts a transaction when start is high in idle, then steps
  // through the append, sweep and emission sequences.
  tdds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: adjacency lists, walk stack and parent table live here, as
  // does the vertex_count register.
  tdds_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .edge_from       (edge_from),
    .edge_to         (edge_to),
    .edge_cost       (edge_cost),
    .cmd             (cmd),
    .stat            (stat),
    .path_vertex     (path_vertex),
    .far_end         (far_end),
    .near_end        (near_end),
    .diameter_length (diameter_length),
    .last_of_path    (last_of_path)
  );

  // A result transaction is emitted in each emission cycle.
  assign result_valid = cmd.emit;

endmodule

// ===== rtl/core/tdds_checker.sv =====
// ----------------------------------------------------------------------------
// tdds_checker
// Port-level checks on command and result sequencing.
// ----------------------------------------------------------------------------
`include "tree_diameter_double_sweep_defines.svh"

module tdds_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic operation,
  input logic result_valid,
  input logic last_of_path
);

  `TDDS_ASSERT_IMP(a_result_busy, clk, rst, result_valid, busy, "result outside busy")
  `TDDS_ASSERT_NXT(a_load_quiet, clk, rst, start && !busy && !operation, !result_valid, "load gave result")
  `TDDS_ASSERT_NXT(a_last_idle, clk, rst, result_valid && last_of_path, !busy, "not idle after last")
  `TDDS_ASSERT_NXT(a_path_gap, clk, rst, result_valid && !last_of_path, busy && !result_valid, "path gap broken")

endmodule

bind tree_diameter_double_sweep tdds_checker u_tdds_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .result_valid (result_valid),
  .last_of_path (last_of_path)
);

// ===== bench/tree_diameter_double_sweep_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_diameter_double_sweep_checker
// Watches the command and result channels, keeps its own copy of the edge
// store and predicts each diameter path; compares every result field.
// ----------------------------------------------------------------------------
module tree_diameter_double_sweep_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tdds_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             operation,
  input  logic [tdds_pkg::VERT_W-1:0]      edge_from,
  input  logic [tdds_pkg::VERT_W-1:0]      edge_to,
  input  logic [tdds_pkg::COST_PORT_W-1:0] edge_cost,
  input  logic                             result_valid,
  input  logic [tdds_pkg::VERT_W-1:0]      path_vertex,
  input  logic [tdds_pkg::VERT_W-1:0]      far_end,
  input  logic [tdds_pkg::VERT_W-1:0]      near_end,
  input  logic [tdds_pkg::DIAM_W-1:0]      diameter_length,
  input  logic                             last_of_path,
  output int                               fail_count,
  output int                               pending
);

  localparam int NV     = tdds_pkg::MAX_VERTICES_DEF;
  localparam int VW     = tdds_pkg::VERT_W;
  localparam int DW     = tdds_pkg::DIAM_W;
  localparam int CPW    = tdds_pkg::COST_PORT_W;
  localparam int NW     = tdds_pkg::CFG_W;
  localparam int SLOTS  = 2 * (NV - 1);
  localparam int NO_ENT = SLOTS;
  localparam longint unsigned DIAM_SAT = (64'd1 << DW) - 1;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] far_v;
    logic [VW-1:0] near_v;
    logic [DW-1:0] length;
    logic          last;
  } path_step_t;

  path_step_t path_due[$];

  // edge store copy
  logic [VW-1:0]  nbr    [SLOTS];
  logic [CPW-1:0] weight [SLOTS];
  int             link   [SLOTS];
  int             head   [NV];
  int             tail   [NV];
  int             n_entries;
  logic [NW-1:0]  vcount;

  // sweep results
  int              parent [NV];
  int              best_v;
  longint unsigned best_d;

  task automatic clear_store();
    for (int i = 0; i < NV; i++) begin
      head[i] = NO_ENT;
      tail[i] = NO_ENT;
    end
    n_entries = 0;
  endtask

  task automatic add_entry(int owner, int other, logic [CPW-1:0] c);
    int e;
    e = n_entries++;
    nbr[e] = VW'(other);
    weight[e] = c;
    link[e] = NO_ENT;
    if (tail[owner] == NO_ENT) head[owner] = e;
    else link[tail[owner]] = e;
    tail[owner] = e;
  endtask

  // depth-first sweep with visited bits; first farthest vertex wins
  task automatic sweep_from(int s, int n, bit rec);
    bit              seen [NV];
    int              sv   [NV];
    int              scur [NV];
    longint unsigned sdist[NV];
    int              sp, e, w;
    longint unsigned d;
    for (int i = 0; i < NV; i++) seen[i] = 0;
    seen[s] = 1;
    best_v = s;
    best_d = 0;
    sv[0] = s; scur[0] = head[s]; sdist[0] = 0; sp = 1;
    if (rec) parent[s] = s;
    while (sp > 0) begin
      e = scur[sp-1];
      if (e == NO_ENT) begin
        sp--;
        continue;
      end
      scur[sp-1] = link[e];
      w = int'(nbr[e]);
      if (w >= n || seen[w]) continue;
      d = sdist[sp-1] + 64'(weight[e]);
      seen[w] = 1;
      if (rec) parent[w] = sv[sp-1];
      if (d > best_d) begin
        best_d = d;
        best_v = w;
      end
      if (sp < NV) begin
        sv[sp] = w; scur[sp] = head[w]; sdist[sp] = d; sp++;
      end
    end
  endtask

  task automatic predict_path();
    int         n, near_v, far_v, r, k;
    path_step_t st;
    n = (vcount == 0) ? 1 : (int'(vcount) > NV) ? NV : int'(vcount);
    sweep_from(0, n, 0);
    near_v = best_v;
    sweep_from(near_v, n, 1);
    far_v = best_v;
    r = far_v;
    k = 0;
    while (k < NV) begin
      st.vertex = VW'(r);
      st.far_v  = VW'(far_v);
      st.near_v = VW'(near_v);
      st.length = DW'((best_d > DIAM_SAT) ? DIAM_SAT : best_d);
      st.last   = (r == near_v) || (k + 1 == NV);
      path_due  = {path_due, st};
      k++;
      if (st.last) break;
      r = parent[r];
    end
    clear_store();
  endtask

  always @(posedge clk) begin
    path_step_t got, want;
    if (rst) begin
      clear_store();
      vcount = NW'(1);
      path_due.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        got = '{path_vertex, far_end, near_end, diameter_length, last_of_path};
        if (path_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected result: vertex %0d far %0d near %0d len %0d last %0b",
                     $time, got.vertex, got.far_v, got.near_v, got.length, got.last);
        end else begin
          want = path_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t path mismatch: exp v%0d f%0d n%0d len %0d last %0b, ",
                        "got v%0d f%0d n%0d len %0d last %0b"}, $time,
                       want.vertex, want.far_v, want.near_v, want.length, want.last,
                       got.vertex, got.far_v, got.near_v, got.length, got.last);
          end
        end
      end
      if (cfg_we) vcount = cfg_data;
      if (start && !busy) begin
        if (operation) predict_path();
        else if (n_entries + 2 <= SLOTS) begin
          add_entry(int'(edge_from), int'(edge_to), edge_cost);
          add_entry(int'(edge_to), int'(edge_from), edge_cost);
        end
      end
    end
    pending = path_due.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

// ===== bench/tb_tree_diameter_double_sweep.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tree_diameter_double_sweep
// Loads weighted trees edge by edge, issues compute commands and lets the
// checker predict and compare every emitted path vertex.
// ----------------------------------------------------------------------------
module tb_tree_diameter_double_sweep;

  localparam int  OP_LOAD    = 0;
  localparam int  OP_COMPUTE = 1;
  localparam int  NV         = tdds_pkg::MAX_VERTICES_DEF;
  localparam int  VW         = tdds_pkg::VERT_W;
  localparam int  NW         = tdds_pkg::CFG_W;
  localparam int  STALL_MAX  = 20000;  // cycles with no transaction
  localparam logic [31:0] COST_MAX = 32'hFFFF_FFFF;

  logic                             clk = 0;
  logic                             rst = 1;
  logic                             cfg_we = 0;
  logic [tdds_pkg::CFG_W-1:0]       cfg_data = 0;
  logic                             start = 0;
  logic                             busy;
  logic                             operation = 0;
  logic [tdds_pkg::VERT_W-1:0]      edge_from = 0;
  logic [tdds_pkg::VERT_W-1:0]      edge_to = 0;
  logic [tdds_pkg::COST_PORT_W-1:0] edge_cost = 0;
  logic                             result_valid;
  logic [tdds_pkg::VERT_W-1:0]      path_vertex, far_end, near_end;
  logic [tdds_pkg::DIAM_W-1:0]      diameter_length;
  logic                             last_of_path;
  int                               fail_count, pending;
  int                               quiet_cycles = 0;
  bit                               gaps_on = 1;

  always #6 clk = ~clk;

  tree_diameter_double_sweep DUT (
    .clk, .rst, .cfg_we, .cfg_data, .start, .busy, .operation, .edge_from,
    .edge_to, .edge_cost, .result_valid, .path_vertex, .far_end, .near_end,
    .diameter_length, .last_of_path
  );

  tree_diameter_double_sweep_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_data, .start, .busy, .operation, .edge_from,
    .edge_to, .edge_cost, .result_valid, .path_vertex, .far_end, .near_end,
    .diameter_length, .last_of_path, .fail_count, .pending
  );

  // watchdog: no transaction of either kind for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("tree_diameter_double_sweep verification failed");
      $finish;
    end
  end

  // optional idle burst before a transaction
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // drive one command at a falling edge, hold until busy is low (accepted
  // at the next rising edge); start is only lowered if a gap follows
  task automatic send_item(int op, int f, int t, logic [31:0] c);
    maybe_gap();
    start     <= 1;
    operation <= 1'(op);
    edge_from <= VW'(f);
    edge_to   <= VW'(t);
    edge_cost <= c;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic end_burst();
    start <= 0;
    @(negedge clk);
  endtask

  // register writes only with nothing outstanding; the trailing wait covers
  // the store clear after the last path vertex
  task automatic set_count(int v);
    end_burst();
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we   <= 1;
    cfg_data <= NW'(v);
    @(negedge clk);
    cfg_we   <= 0;
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return COST_MAX;
      2, 3:    return $urandom_range(0, 9);  // small values make ties likely
      default: return $urandom;
    endcase
  endfunction

  // random tree on n vertices, edges in shuffled order with shuffled
  // endpoints, occasional junk edges, then a compute
  task automatic send_tree(int n);
    int ea[$], eb[$];
    int i, j, tmp;
    for (i = 1; i < n; i++) begin
      ea = {ea, int'($urandom_range(0, i - 1))};
      eb = {eb, i};
    end
    for (i = ea.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ea[i]; ea[i] = ea[j]; ea[j] = tmp;
      tmp = eb[i]; eb[i] = eb[j]; eb[j] = tmp;
    end
    for (i = 0; i < ea.size(); i++) begin
      if ($urandom_range(0, 1)) send_item(OP_LOAD, ea[i], eb[i], pick_cost());
      else                      send_item(OP_LOAD, eb[i], ea[i], pick_cost());
      // noise: an edge to a vertex beyond the count is skipped by the sweeps
      if (n < NV && $urandom_range(0, 9) == 0)
        send_item(OP_LOAD, $urandom_range(0, n - 1), $urandom_range(n, NV - 1), $urandom);
    end
    send_item(OP_COMPUTE, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int n;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // empty store at the reset count: single vertex path
    send_item(OP_COMPUTE, 0, 0, 0);

    // full range endpoints and extreme costs, self loop, repeated edge
    set_count(64);
    send_item(OP_LOAD, 0, 63, COST_MAX);
    send_item(OP_LOAD, 63, 62, 0);
    send_item(OP_LOAD, 0, 1, COST_MAX);
    send_item(OP_LOAD, 1, 1, 5);
    send_item(OP_LOAD, 0, 63, 7);
    send_item(OP_COMPUTE, 63, 63, COST_MAX);

    // tie between two leaves; edge past the count is skipped
    set_count(3);
    send_item(OP_LOAD, 0, 1, 5);
    send_item(OP_LOAD, 2, 0, 5);
    send_item(OP_LOAD, 2, 40, 100);
    send_item(OP_COMPUTE, 0, 0, 0);

    // count 0 behaves as 1: edge ignored, no edges visible
    set_count(0);
    send_item(OP_LOAD, 0, 1, 3);
    send_item(OP_COMPUTE, 0, 0, 0);

    // all-zero costs: every distance ties
    set_count(4);
    send_item(OP_LOAD, 0, 1, 0);
    send_item(OP_LOAD, 1, 2, 0);
    send_item(OP_LOAD, 3, 0, 0);
    send_item(OP_COMPUTE, 0, 0, 0);

    // count above the vertex limit behaves as 64; full chain fills the
    // store and the extra load is dropped; 64-vertex path
    set_count(127);
    for (int i = 0; i < NV - 1; i++) send_item(OP_LOAD, i, i + 1, COST_MAX);
    send_item(OP_LOAD, 5, 6, 1);
    send_item(OP_COMPUTE, 0, 0, 0);

    // random small trees, count set per phase
    for (int p = 0; p < 6; p++) begin
      if (p >= 4) gaps_on = 0;
      n = $urandom_range(1, 8);
      set_count(n);
      send_tree(n);
      if ($urandom_range(0, 1)) send_tree(n);
    end
    end_burst();

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0) $display("tree_diameter_double_sweep verification clean");
    else $display("tree_diameter_double_sweep verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tdds_pkg.sv
rtl/core/tdds_ctrl.sv
rtl/core/tdds_dp.sv
rtl/core/tree_diameter_double_sweep.sv
rtl/core/tdds_checker.sv
bench/tree_diameter_double_sweep_checker.sv
bench/tb_tree_diameter_double_sweep.sv
